>>> design/cts_pkg.sv
package cts_pkg;

  // chip year at which the epoch starts
  localparam int unsigned EPOCH_YEAR_OFFSET  = 2;
  // multiples of four below the epoch chip year
  localparam int unsigned LEAPS_BEFORE_EPOCH = (EPOCH_YEAR_OFFSET + 3) / 4;

  localparam int unsigned SECS_PER_DAY   = 86400;
  localparam int unsigned SECS_PER_HOUR  = 3600;
  localparam int unsigned SECS_PER_MIN   = 60;
  localparam int unsigned USEC_PER_HSEC  = 10000;
  localparam int unsigned DAYS_PER_YEAR  = 365;

  localparam int unsigned DAYS_W = 17;
  localparam int unsigned HMS_W  = 17;
  localparam int unsigned USEC_W = 22;
  localparam int unsigned SECS_W = 31;
  localparam int unsigned PROD_W = 34;

  localparam logic [SECS_W-1:0] MAX_SECONDS = '1;

  // register index codes on the configuration port
  typedef enum logic [0:0] {
    REG_FIELD_FORMAT = 1'b0
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] hundredths;
    logic [7:0] sec_byte;
    logic [7:0] min_byte;
    logic [7:0] hour_byte;
    logic [7:0] day_byte;
    logic [7:0] month_byte;
    logic [7:0] year_byte;
    logic [7:0] weekday_byte;
  } raw_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] hsec;
    logic [5:0] sec;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day;
    logic [3:0] mon;
    logic [7:0] year;
  } dec_t;

  typedef struct packed {
    logic              ok;
    logic [DAYS_W-1:0] days;
    logic [HMS_W-1:0]  hms;
    logic [USEC_W-1:0] usec;
  } days_t;

  typedef struct packed {
    logic              ok;
    logic [SECS_W-1:0] secs;
    logic [USEC_W-1:0] usec;
  } res_t;

  // days elapsed in a common year before the first of the given month
  function automatic logic [8:0] cum_days(input logic [3:0] mon);
    logic [8:0] d;
    unique case (mon)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

>>> design/cts_decode.sv
module cts_decode (
  input  logic          clk,
  input  logic          rst,
  input  logic          bcd,
  input  logic          in_valid,
  output logic          in_ready,
  input  cts_pkg::raw_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output cts_pkg::dec_t out_data
);

  // bcd digits are not checked, so nibbles above 9 pass through
  function automatic logic [7:0] dec_byte(input logic [7:0] b, input logic is_bcd);
    logic [7:0] hi;
    hi = {4'd0, b[7:4]};
    return is_bcd ? (8'({4'd0, b[3:0]}) + (hi << 3) + (hi << 1)) : b;
  endfunction

  logic [7:0]    sec, minute, hour, day, mon, year, wday;
  cts_pkg::dec_t dec_next;
  logic          vld;
  cts_pkg::dec_t dec;

  always_comb begin
    sec    = dec_byte(in_data.sec_byte, bcd);
    minute = dec_byte(in_data.min_byte, bcd);
    hour   = dec_byte(in_data.hour_byte, bcd);
    day    = dec_byte(in_data.day_byte, bcd);
    mon    = dec_byte(in_data.month_byte, bcd);
    year   = dec_byte(in_data.year_byte, bcd);
    wday   = dec_byte(in_data.weekday_byte, bcd);

    dec_next.ok = (mon >= 8'd1) && (mon <= 8'd12) && (day >= 8'd1) && (day <= 8'd31) &&
                  (wday <= 8'd7) && (hour <= 8'd23) && (minute <= 8'd59) &&
                  (sec <= 8'd59) && (year >= 8'(cts_pkg::EPOCH_YEAR_OFFSET));
    dec_next.hsec   = bcd ? 8'd0 : in_data.hundredths;
    dec_next.sec    = sec[5:0];
    dec_next.minute = minute[5:0];
    dec_next.hour   = hour[4:0];
    dec_next.day    = day[4:0];
    dec_next.mon    = mon[3:0];
    dec_next.year   = year;
  end

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_data  = dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      dec <= dec_next;
    end
  end

endmodule

>>> design/cts_days.sv
module cts_days (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  cts_pkg::dec_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output cts_pkg::days_t out_data
);

  localparam int unsigned DW = cts_pkg::DAYS_W;
  localparam int unsigned HW = cts_pkg::HMS_W;
  localparam int unsigned UW = cts_pkg::USEC_W;

  logic [DW-1:0]  ydiff, leaps, year_days, mon_days;
  logic           leap;
  cts_pkg::days_t days_next;
  logic           vld;
  cts_pkg::days_t days_q;

  always_comb begin
    // whole years: 365 each plus one per chip year that is a multiple of four
    ydiff     = DW'(in_data.year) - DW'(cts_pkg::EPOCH_YEAR_OFFSET);
    leaps     = DW'((9'({1'b0, in_data.year}) + 9'd3) >> 2)
                - DW'(cts_pkg::LEAPS_BEFORE_EPOCH);
    year_days = DW'(ydiff * DW'(cts_pkg::DAYS_PER_YEAR)) + leaps;
    leap      = (in_data.year[1:0] == 2'b00);
    mon_days  = DW'(cts_pkg::cum_days(in_data.mon))
                + DW'(leap && (in_data.mon > 4'd2));

    days_next.ok   = in_data.ok;
    days_next.days = year_days + mon_days + DW'(in_data.day) - DW'(1);
    days_next.hms  = HW'(HW'(in_data.hour) * HW'(cts_pkg::SECS_PER_HOUR))
                   + HW'(HW'(in_data.minute) * HW'(cts_pkg::SECS_PER_MIN))
                   + HW'(in_data.sec);
    days_next.usec = UW'(UW'(in_data.hsec) * UW'(cts_pkg::USEC_PER_HSEC));
  end

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_data  = days_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      days_q <= days_next;
    end
  end

endmodule

>>> design/cts_secs.sv
module cts_secs (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  cts_pkg::days_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output cts_pkg::res_t  out_data
);

  localparam int unsigned PW = cts_pkg::PROD_W;
  localparam int unsigned SW = PW + 1;

  // multiply stage
  logic                        m_vld, m_ready;
  logic                        m_ok;
  logic [PW-1:0]               m_prod;
  logic [cts_pkg::HMS_W-1:0]   m_hms;
  logic [cts_pkg::USEC_W-1:0]  m_usec;

  // sum and range stage
  logic                        r_vld;
  logic [SW-1:0]               sum;
  logic                        fits;
  cts_pkg::res_t               res_next;
  cts_pkg::res_t               res;

  assign in_ready = !m_vld || m_ready;
  assign m_ready  = !r_vld || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else if (in_ready) begin
      m_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      m_ok   <= in_data.ok;
      m_prod <= PW'(in_data.days) * PW'(cts_pkg::SECS_PER_DAY);
      m_hms  <= in_data.hms;
      m_usec <= in_data.usec;
    end
  end

  always_comb begin
    sum  = SW'(m_prod) + SW'(m_hms);
    fits = m_ok && (sum <= SW'(cts_pkg::MAX_SECONDS));
    res_next.ok   = fits;
    res_next.secs = fits ? sum[cts_pkg::SECS_W-1:0] : '0;
    res_next.usec = fits ? m_usec : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_vld <= 1'b0;
    end else if (m_ready) begin
      r_vld <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (m_ready && m_vld) begin
      res <= res_next;
    end
  end

  assign out_valid = r_vld;
  assign out_data  = res;

endmodule

>>> design/calendar_to_unix_seconds_core.sv
// throughput: one request per cycle while the result side is not stalled, four
// register stages (decode, day count, day-to-seconds multiply, final sum and
// range check), valid bits ride along
// a stall on the result side backs up stage by stage, bubbles are squeezed out
// reset (rst, synchronous): empties all stages and sets field_format to binary
module calendar_to_unix_seconds_core (
  input  logic        clk,
  input  logic        rst,

  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  // request channel
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [7:0]  hundredths,
  input  logic [7:0]  sec_byte,
  input  logic [7:0]  min_byte,
  input  logic [7:0]  hour_byte,
  input  logic [7:0]  day_byte,
  input  logic [7:0]  month_byte,
  input  logic [7:0]  year_byte,
  input  logic [7:0]  weekday_byte,

  // result channel
  output logic        res_valid,
  input  logic        res_stall,
  output logic [30:0] unix_seconds,
  output logic [21:0] microseconds,
  output logic        valid_res
);

  // ---------------------------------------------------------------------------
  // configuration register: one bit, 0 binary fields, 1 bcd fields
  // ---------------------------------------------------------------------------
  logic             field_format;
  cts_pkg::reg_idx_t reg_sel;

  // registers sit on word addresses, index is the word number
  assign reg_sel = cts_pkg::reg_idx_t'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_format <= 1'b0;
    end else if (psel && penable && pwrite && pready && (reg_sel == cts_pkg::REG_FIELD_FORMAT)) begin
      field_format <= pwdata[0];
    end
  end

  // read data, zero for addresses past the register list
  always_comb begin
    prdata = '0;
    if (reg_sel == cts_pkg::REG_FIELD_FORMAT) begin
      prdata = {31'd0, field_format};
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline
  // ---------------------------------------------------------------------------
  cts_pkg::raw_t  raw;
  cts_pkg::dec_t  dec;
  cts_pkg::days_t days;
  cts_pkg::res_t  res;
  logic           req_ready;
  logic           dec_valid, dec_ready;
  logic           days_valid, days_ready;

  always_comb begin
    raw.hundredths   = hundredths;
    raw.sec_byte     = sec_byte;
    raw.min_byte     = min_byte;
    raw.hour_byte    = hour_byte;
    raw.day_byte     = day_byte;
    raw.month_byte   = month_byte;
    raw.year_byte    = year_byte;
    raw.weekday_byte = weekday_byte;
  end

  // stage 1: bcd or binary decode, range checks
  cts_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .bcd       (field_format),
    .in_valid  (req_valid),
    .in_ready  (req_ready),
    .in_data   (raw),
    .out_valid (dec_valid),
    .out_ready (dec_ready),
    .out_data  (dec)
  );

  // stage 2: days since epoch, seconds within the day, microseconds
  cts_days u_days (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_data   (dec),
    .out_valid (days_valid),
    .out_ready (days_ready),
    .out_data  (days)
  );

  // stages 3 and 4: days times 86400, add time of day, overflow check
  cts_secs u_secs (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (days_valid),
    .in_ready  (days_ready),
    .in_data   (days),
    .out_valid (res_valid),
    .out_ready (!res_stall),
    .out_data  (res)
  );

  assign req_stall    = !req_ready;
  assign unix_seconds = res.secs;
  assign microseconds = res.usec;
  assign valid_res    = res.ok;

endmodule

>>> design/cts_checker.sv
module cts_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_stall,
  input logic        res_valid,
  input logic        res_stall,
  input logic [30:0] unix_seconds,
  input logic [21:0] microseconds,
  input logic        valid_res
);

  // a held result keeps its payload
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(unix_seconds) &&
                               $stable(microseconds) && $stable(valid_res))
    else $error("result changed while stalled");

  // requests are only held off when the result side is backed up
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> res_valid && res_stall)
    else $error("request stalled with result side free");

  // rejected or overflowing requests give zero time
  a_zero_invalid: assert property (@(posedge clk) disable iff (rst)
    res_valid && !valid_res |-> unix_seconds == 31'd0 && microseconds == 22'd0)
    else $error("nonzero time on invalid result");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

endmodule

bind calendar_to_unix_seconds_core cts_checker u_cts_checker (
  .clk          (clk),
  .rst          (rst),
  .req_stall    (req_stall),
  .res_valid    (res_valid),
  .res_stall    (res_stall),
  .unix_seconds (unix_seconds),
  .microseconds (microseconds),
  .valid_res    (valid_res)
);
